### rtl/core/tes_pkg.sv
// ----------------------------------------------------------------------------
// Timed event scheduler package
// Shared constants and the entry type for the sorted cell chain.
// ----------------------------------------------------------------------------
package tes_pkg;

   localparam int MAX_EVENTS = 32;
   localparam int KIND_COUNT = 64;

   localparam logic [26:0] INIT_SLICE = 27'd20000;
   localparam logic [26:0] SLICE_CAP  = 27'd100000000;
   localparam logic [26:0] SLICE_BUMP = 27'd10000;

   localparam logic [2:0] MODE_SCHED   = 3'd0;
   localparam logic [2:0] MODE_UNSCHED = 3'd1;
   localparam logic [2:0] MODE_REMOVE  = 3'd2;
   localparam logic [2:0] MODE_QUERY   = 3'd3;
   localparam logic [2:0] MODE_ADVANCE = 3'd4;
   localparam logic [2:0] MODE_CLEAR   = 3'd5;

   typedef struct packed {
      logic [63:0] due;
      logic [5:0]  kind;
      logic [63:0] word;
   } entry_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic        insert;   // place new entry in sorted position
      logic        shift;    // whole chain moves one step toward the head
      logic        remove;   // drop first cell whose hit flag is set
      logic [63:0] new_due;
      logic [5:0]  new_kind;
      logic [63:0] new_word;
      logic        match_word; // hit needs word equality too
      logic [5:0]  match_kind;
   } chain_cmd_type;

endpackage

### rtl/core/tes_cell.sv
// ----------------------------------------------------------------------------
// Timed event scheduler cell
// One slot of the sorted chain: holds an entry and a valid bit.
// ----------------------------------------------------------------------------
module tes_cell import tes_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   input  logic          clear,
   input  entry_type     prev_entry,   // neighbor toward the head
   input  logic          prev_valid,
   input  logic          prev_goes_after, // new entry belongs after prev
   input  entry_type     next_entry,   // neighbor toward the tail
   input  logic          next_valid,
   input  logic          prev_hit_seen, // a hit exists at a lower index
   output entry_type     entry_out,
   output logic          valid_out,
   output logic          goes_after,   // new entry belongs after this cell
   output logic          hit
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   assign entry_out = entry_ff;
   assign valid_out = valid_ff;
   assign goes_after = valid_ff && ($signed(entry_ff.due) <= $signed(cmd.new_due));
   assign hit = valid_ff && (entry_ff.kind == cmd.match_kind) &&
                (!cmd.match_word || entry_ff.word == cmd.new_word);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (cmd.insert) begin
         if (!goes_after) begin
            if (prev_goes_after) begin
               entry_in = '{due: cmd.new_due, kind: cmd.new_kind, word: cmd.new_word};
               valid_in = 1'b1;
            end else begin
               entry_in = prev_entry;
               valid_in = prev_valid;
            end
         end
      end else if (cmd.shift || (cmd.remove && (hit || prev_hit_seen))) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

### rtl/core/tes_chain.sv
// ----------------------------------------------------------------------------
// Timed event scheduler chain
// Row of cells kept sorted by due tick, with the head entry at index zero.
// ----------------------------------------------------------------------------
module tes_chain import tes_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   input  logic          clear,
   output entry_type     head,
   output logic          head_valid,
   output logic          any_hit,
   output entry_type     first_hit_entry,
   output logic          full
);

   entry_type             ent [MAX_EVENTS];
   logic [MAX_EVENTS-1:0] vld, after, hit, seen;
   entry_type             last_hit;

   genvar g;
   generate
      for (g = 0; g < MAX_EVENTS; g++) begin : g_cell
         entry_type pe, ne;
         logic pv, pa, nv, ps;
         if (g == 0) begin : g_h
            assign pe = ent[0];
            assign pv = 1'b0;
            assign pa = 1'b1;
            assign ps = 1'b0;
         end else begin : g_m
            assign pe = ent[g-1];
            assign pv = vld[g-1];
            assign pa = after[g-1];
            assign ps = seen[g-1];
         end
         if (g == MAX_EVENTS - 1) begin : g_t
            assign ne = ent[g];
            assign nv = 1'b0;
         end else begin : g_n
            assign ne = ent[g+1];
            assign nv = vld[g+1];
         end
         assign seen[g] = ps | hit[g];
         tes_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd), .clear(clear),
            .prev_entry(pe), .prev_valid(pv), .prev_goes_after(pa),
            .next_entry(ne), .next_valid(nv), .prev_hit_seen(ps),
            .entry_out(ent[g]), .valid_out(vld[g]), .goes_after(after[g]),
            .hit(hit[g])
         );
      end
   endgenerate

   always_comb begin
      last_hit = ent[0];
      for (int i = MAX_EVENTS - 1; i >= 0; i--) begin
         if (hit[i]) last_hit = ent[i];
      end
   end

   assign head = ent[0];
   assign head_valid = vld[0];
   assign any_hit = |hit;
   assign first_hit_entry = last_hit;
   assign full = vld[MAX_EVENTS-1];

endmodule

### rtl/core/timed_event_scheduler_core.sv
// ----------------------------------------------------------------------------
// Timed event scheduler core
// Time-ordered event queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Pending events live in a chain of MAX_EVENTS cells kept sorted by due tick,
// with the earliest at the head. A schedule inserts in the accepting cycle,
// unless the chain is full, and clear empties the chain in the accepting
// cycle. A query looks at the chain in the cycle after acceptance;
// unschedule and remove-kind drop one matching cell per cycle and answer
// once they see that no match is left. An advance fires one due event per
// cycle from the head while its result register is free, then moves to a
// slice state for the slice result. Every result is held in an output
// register, and a new request is taken only once the last result transfer
// of the previous one has completed.
module timed_event_scheduler_core import tes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [30:0] req_executed_in_slice,
   input  logic [31:0] req_delay_cycles,
   input  logic [5:0]  req_event_kind,
   input  logic [63:0] req_user_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fired,
   output logic [5:0]  rsp_fired_kind,
   output logic [63:0] rsp_fired_word,
   output logic [30:0] rsp_lateness,
   output logic [31:0] rsp_cycles_left,
   output logic        rsp_found,
   output logic        rsp_queue_full,
   output logic [26:0] rsp_new_slice,
   output logic        rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WORK = 2'd1;
   localparam logic [1:0] ST_SLICE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  mode_ff, mode_in;
   logic [5:0]  kind_ff, kind_in;
   logic [63:0] word_ff, word_in;
   logic [63:0] now_ff, now_in;
   logic [63:0] ticks_ff, ticks_in;
   logic [26:0] slice_ff, slice_in;
   logic        found_ff, found_in;
   logic [31:0] left_ff, left_in;

   logic        rv_ff, rv_in;
   logic        r_fired_ff, r_fired_in, r_found_ff, r_found_in;
   logic        r_full_ff, r_full_in, r_last_ff, r_last_in;
   logic [5:0]  r_kind_ff, r_kind_in;
   logic [63:0] r_word_ff, r_word_in;
   logic [30:0] r_late_ff, r_late_in;
   logic [31:0] r_left_ff, r_left_in;
   logic [26:0] r_slice_ff, r_slice_in;

   chain_cmd_type cmd;
   logic          clear;
   entry_type     head, hit_entry;
   logic          head_valid, any_hit, full;

   logic        out_free;
   logic        req_take;
   logic [63:0] req_now, late_full, gap_ticks, diff;
   logic        kind_ok;

   tes_chain u_chain (
      .clock(clock), .reset(reset), .cmd(cmd), .clear(clear),
      .head(head), .head_valid(head_valid), .any_hit(any_hit),
      .first_hit_entry(hit_entry), .full(full)
   );

   assign out_free  = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign req_take  = req_valid && req_ready;
   assign req_now   = ticks_ff + {33'd0, req_executed_in_slice};
   assign kind_ok   = ({2'b00, req_event_kind} < 8'(KIND_COUNT));
   assign late_full = ticks_ff - head.due;
   assign gap_ticks = head.due - ticks_ff;
   assign diff      = hit_entry.due - now_ff;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; kind_in = kind_ff; word_in = word_ff;
      now_in = now_ff; ticks_in = ticks_ff; slice_in = slice_ff;
      found_in = found_ff; left_in = left_ff;
      rv_in = rv_ff && !rsp_ready;
      r_fired_in = r_fired_ff; r_found_in = r_found_ff; r_full_in = r_full_ff;
      r_last_in = r_last_ff; r_kind_in = r_kind_ff; r_word_in = r_word_ff;
      r_late_in = r_late_ff; r_left_in = r_left_ff; r_slice_in = r_slice_ff;
      cmd = '0;
      cmd.new_due  = req_now + {{32{req_delay_cycles[31]}}, req_delay_cycles};
      cmd.new_kind = req_event_kind;
      cmd.new_word = req_user_word;
      cmd.match_kind = kind_ff;
      clear = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_in = req_mode; kind_in = req_event_kind; word_in = req_user_word;
               now_in = req_now; found_in = 1'b0; left_in = '0;
               r_fired_in = 1'b0; r_found_in = 1'b0; r_full_in = 1'b0;
               r_last_in = 1'b1; r_kind_in = '0; r_word_in = '0;
               r_late_in = '0; r_left_in = '0; r_slice_in = '0;
               unique case (req_mode)
                  MODE_SCHED: begin
                     if (kind_ok) begin
                        if (full) r_full_in = 1'b1;
                        else cmd.insert = 1'b1;
                     end
                     rv_in = 1'b1;
                  end
                  MODE_UNSCHED, MODE_REMOVE: state_in = ST_WORK;
                  MODE_QUERY: state_in = ST_WORK;
                  MODE_ADVANCE: begin
                     ticks_in = req_now;
                     state_in = ST_WORK;
                  end
                  MODE_CLEAR: begin
                     clear = 1'b1;
                     rv_in = 1'b1;
                  end
                  default: rv_in = 1'b1;
               endcase
            end
         end
         ST_WORK: begin
            cmd.match_word = (mode_ff == MODE_UNSCHED);
            cmd.new_word = word_ff;
            unique case (mode_ff)
               MODE_QUERY: begin
                  r_found_in = any_hit;
                  rv_in = 1'b1;
                  state_in = ST_IDLE;
               end
               MODE_ADVANCE: begin
                  if (head_valid && ($signed(head.due) <= $signed(ticks_ff))) begin
                     if (out_free) begin
                        cmd.shift = 1'b1;
                        rv_in = 1'b1;
                        r_fired_in = 1'b1; r_kind_in = head.kind; r_word_in = head.word;
                        r_late_in = (late_full > 64'h7FFFFFFF) ? 31'h7FFFFFFF
                                                               : late_full[30:0];
                        r_last_in = 1'b0; r_slice_in = '0;
                     end
                  end else begin
                     state_in = ST_SLICE;
                  end
               end
               default: begin
                  // unschedule or remove-kind: drop the first match each cycle
                  if (any_hit) begin
                     cmd.remove = 1'b1;
                     found_in = 1'b1;
                     if ($signed(now_ff) <= $signed(hit_entry.due)) begin
                        left_in = (diff > 64'h7FFFFFFF) ? 32'h7FFFFFFF : diff[31:0];
                     end else if ((now_ff - hit_entry.due) > 64'h80000000) begin
                        left_in = 32'h80000000;
                     end else begin
                        left_in = diff[31:0];
                     end
                  end else begin
                     if (mode_ff == MODE_UNSCHED) begin
                        r_found_in = found_ff;
                        r_left_in = left_ff;
                     end
                     rv_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_SLICE: begin
            if (out_free) begin
               if (!head_valid) begin
                  if (slice_ff < SLICE_BUMP) slice_in = slice_ff + SLICE_BUMP;
               end else begin
                  slice_in = (gap_ticks > {37'd0, SLICE_CAP}) ? SLICE_CAP : gap_ticks[26:0];
               end
               rv_in = 1'b1;
               r_fired_in = 1'b0; r_kind_in = '0; r_word_in = '0; r_late_in = '0;
               r_last_in = 1'b1; r_slice_in = slice_in;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         ticks_ff <= '0;
         slice_ff <= INIT_SLICE;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         ticks_ff <= ticks_in;
         slice_ff <= slice_in;
      end
      mode_ff <= mode_in; kind_ff <= kind_in; word_ff <= word_in; now_ff <= now_in;
      found_ff <= found_in; left_ff <= left_in;
      r_fired_ff <= r_fired_in; r_found_ff <= r_found_in; r_full_ff <= r_full_in;
      r_last_ff <= r_last_in; r_kind_ff <= r_kind_in; r_word_ff <= r_word_in;
      r_late_ff <= r_late_in; r_left_ff <= r_left_in; r_slice_ff <= r_slice_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_fired       = r_fired_ff;
   assign rsp_fired_kind  = r_kind_ff;
   assign rsp_fired_word  = r_word_ff;
   assign rsp_lateness    = r_late_ff;
   assign rsp_cycles_left = r_left_ff;
   assign rsp_found       = r_found_ff;
   assign rsp_queue_full  = r_full_ff;
   assign rsp_new_slice   = r_slice_ff;
   assign rsp_last        = r_last_ff;

endmodule

### dv/tes_event_checker.sv
// ----------------------------------------------------------------------------
// Timed event scheduler checker
// Watches the request and response channels, keeps its own copy of the
// sorted event store, and compares every response transfer in order.
// ----------------------------------------------------------------------------
module tes_event_checker import tes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [30:0] req_executed_in_slice,
   input  logic [31:0] req_delay_cycles,
   input  logic [5:0]  req_event_kind,
   input  logic [63:0] req_user_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_fired,
   input  logic [5:0]  rsp_fired_kind,
   input  logic [63:0] rsp_fired_word,
   input  logic [30:0] rsp_lateness,
   input  logic [31:0] rsp_cycles_left,
   input  logic        rsp_found,
   input  logic        rsp_queue_full,
   input  logic [26:0] rsp_new_slice,
   input  logic        rsp_last,
   output int          error_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        fired;
      logic [5:0]  fired_kind;
      logic [63:0] fired_word;
      logic [30:0] lateness;
      logic [31:0] cycles_left;
      logic        found;
      logic        queue_full;
      logic [26:0] new_slice;
      logic        last;
   } outcome_type;

   outcome_type outcome_queue[$];
   logic signed [63:0] ev_due[$];
   logic [5:0]         ev_kind[$];
   logic [63:0]        ev_word[$];
   logic signed [63:0] tick_count;
   logic [26:0]        cur_slice;

   // Remaining cycles from now to due, saturated to a 32-bit signed value.
   function automatic logic [31:0] clip_remaining(logic signed [63:0] due,
                                                  logic signed [63:0] now);
      logic [63:0] mag;
      if (now <= due) begin
         mag = due - now;
         return (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
      end
      mag = now - due;
      if (mag > 64'h80000000) mag = 64'h80000000;
      return 32'(64'd0 - mag);
   endfunction

   task automatic schedule_outcomes(logic [2:0] mode, logic [30:0] exec,
                                    logic [31:0] delay, logic [5:0] kind,
                                    logic [63:0] word);
      outcome_type o;
      logic signed [63:0] now, due, late;
      int pos, i;
      now = tick_count + {33'd0, exec};
      o = '0;
      o.last = 1'b1;
      case (mode)
         MODE_ADVANCE: begin
            tick_count = now;
            while (ev_due.size() > 0 && ev_due[0] <= tick_count) begin
               outcome_type f;
               f = '0;
               late = tick_count - ev_due[0];
               f.fired = 1'b1;
               f.fired_kind = ev_kind[0];
               f.fired_word = ev_word[0];
               f.lateness = ($unsigned(late) > 64'h7FFFFFFF) ? 31'h7FFFFFFF
                                                             : late[30:0];
               outcome_queue.insert(outcome_queue.size(), f);
               void'(ev_due.pop_front());
               void'(ev_kind.pop_front());
               void'(ev_word.pop_front());
            end
            if (ev_due.size() == 0) begin
               if (cur_slice < SLICE_BUMP) cur_slice = cur_slice + SLICE_BUMP;
            end else begin
               late = ev_due[0] - tick_count;
               cur_slice = ($unsigned(late) > 64'd100000000) ? SLICE_CAP : late[26:0];
            end
            o.new_slice = cur_slice;
         end
         MODE_SCHED: begin
            if (ev_due.size() >= MAX_EVENTS) begin
               o.queue_full = 1'b1;
            end else begin
               due = now + {{32{delay[31]}}, delay};
               pos = ev_due.size();
               for (i = 0; i < ev_due.size(); i++)
                  if (ev_due[i] > due) begin
                     pos = i;
                     break;
                  end
               ev_due.insert(pos, due);
               ev_kind.insert(pos, kind);
               ev_word.insert(pos, word);
            end
         end
         MODE_UNSCHED: begin
            i = 0;
            while (i < ev_due.size()) begin
               if (ev_kind[i] == kind && ev_word[i] == word) begin
                  o.cycles_left = clip_remaining(ev_due[i], now);
                  o.found = 1'b1;
                  ev_due.delete(i);
                  ev_kind.delete(i);
                  ev_word.delete(i);
               end else begin
                  i++;
               end
            end
         end
         MODE_REMOVE: begin
            i = 0;
            while (i < ev_due.size()) begin
               if (ev_kind[i] == kind) begin
                  ev_due.delete(i);
                  ev_kind.delete(i);
                  ev_word.delete(i);
               end else begin
                  i++;
               end
            end
         end
         MODE_QUERY: begin
            for (i = 0; i < ev_kind.size(); i++)
               if (ev_kind[i] == kind) o.found = 1'b1;
         end
         MODE_CLEAR: begin
            ev_due.delete();
            ev_kind.delete();
            ev_word.delete();
         end
         default: ;
      endcase
      outcome_queue.insert(outcome_queue.size(), o);
   endtask

   always @(posedge clock) begin
      outcome_type seen, want;
      if (reset) begin
         error_count <= 0;
         outcome_queue.delete();
         ev_due.delete();
         ev_kind.delete();
         ev_word.delete();
         tick_count = '0;
         cur_slice = INIT_SLICE;
      end else begin
         // Responses are checked before the request so a same-edge pair
         // never sees the outcome of a request issued at that same edge.
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_fired, rsp_fired_kind, rsp_fired_word, rsp_lateness,
                     rsp_cycles_left, rsp_found, rsp_queue_full, rsp_new_slice,
                     rsp_last};
            if (outcome_queue.size() == 0) begin
               $display("%0t: unexpected response transfer %h", $time, seen);
               error_count <= error_count + 1;
            end else begin
               want = outcome_queue.pop_front();
               if (seen !== want) begin
                  $display("%0t: response mismatch expected %h actual %h",
                           $time, want, seen);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            schedule_outcomes(req_mode, req_executed_in_slice, req_delay_cycles,
                              req_event_kind, req_user_word);
      end
      pending_results = outcome_queue.size();
   end
endmodule

### dv/tb_timed_event_scheduler_core.sv
// ----------------------------------------------------------------------------
// Timed event scheduler testbench
// Drives directed and random scheduler requests with random idling on both
// channels; the checker predicts and compares all response transfers.
// ----------------------------------------------------------------------------
module tb_timed_event_scheduler_core;
   timeunit 1ns;
   timeprecision 1ps;
   import tes_pkg::*;

   // Mode codes that the block does not use.
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = MODE_QUERY;
   logic [30:0] req_executed_in_slice = '0;
   logic [31:0] req_delay_cycles = '0;
   logic [5:0]  req_event_kind = '0;
   logic [63:0] req_user_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_fired;
   logic [5:0]  rsp_fired_kind;
   logic [63:0] rsp_fired_word;
   logic [30:0] rsp_lateness;
   logic [31:0] rsp_cycles_left;
   logic        rsp_found;
   logic        rsp_queue_full;
   logic [26:0] rsp_new_slice;
   logic        rsp_last;
   int          error_count;
   int          pending_results;
   bit          stall_free = 1'b0;

   // A small pool of words makes unschedule hits and duplicate entries common.
   logic [63:0] word_pool[4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                                 64'h1234_5678_9ABC_DEF0, 64'h8000_0000_0000_0001};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   timed_event_scheduler_core i_dut (.*);

   tes_event_checker i_checker (.*);

   // Random idle length: mostly short, now and then long.
   function automatic int idle_cycles();
      if (stall_free) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
   endfunction

   // The receiver toggles its ready on its own schedule.
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         hold = idle_cycles();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // One request transfer: valid rises at a clock edge and stays until accepted.
   task automatic send_request(logic [2:0] mode, logic [30:0] exec,
                               logic [31:0] delay, logic [5:0] kind,
                               logic [63:0] word);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_executed_in_slice <= exec;
      req_delay_cycles <= delay;
      req_event_kind <= kind;
      req_user_word <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random();
      logic [2:0]  mode;
      logic [30:0] exec;
      logic [31:0] delay;
      logic [5:0]  kind;
      logic [63:0] word;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) mode = MODE_SCHED;
      else if (pick < 55) mode = MODE_UNSCHED;
      else if (pick < 62) mode = MODE_REMOVE;
      else if (pick < 70) mode = MODE_QUERY;
      else if (pick < 96) mode = MODE_ADVANCE;
      else if (pick < 98) mode = MODE_CLEAR;
      else mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      pick = $urandom_range(0, 9);
      exec = (pick == 0) ? 31'($urandom) : (pick < 3) ? '0 : 31'($urandom_range(0, 3000));
      pick = $urandom_range(0, 9);
      if (pick == 0) delay = $urandom;
      else if (pick == 1) delay = -32'($urandom_range(0, 2000));
      else delay = $urandom_range(0, 4000);
      kind = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
      word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : word_pool[$urandom_range(0, 3)];
      send_request(mode, exec, delay, kind, word);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: field extremes, every mode, equal-time ordering,
      // saturated lateness and remaining cycles, both unused modes and overflow.
      send_request(MODE_ADVANCE, '0, '0, '0, '0);
      send_request(MODE_SCHED, '0, 32'd100, 6'd1, 64'hA);
      send_request(MODE_SCHED, '0, 32'd100, 6'd2, 64'hB);
      send_request(MODE_SCHED, 31'h7FFFFFFF, 32'h7FFFFFFF, 6'd63, '1);
      send_request(MODE_SCHED, '0, 32'h80000000, 6'd3, 64'h0);
      send_request(MODE_QUERY, '0, '0, 6'd63, '0);
      send_request(MODE_QUERY, '0, '0, 6'd40, '0);
      send_request(MODE_UNSCHED, '0, '0, 6'd63, '1);
      send_request(MODE_UNSCHED, '0, '0, 6'd9, 64'h5);
      send_request(MODE_SCHED, '0, 32'h7FFFFFFF, 6'd4, 64'h7);
      send_request(MODE_SCHED, '0, 32'h7FFFFFFF, 6'd4, 64'h7);
      send_request(MODE_UNSCHED, 31'h7FFFFFFF, '0, 6'd4, 64'h7);
      send_request(MODE_ADVANCE, 31'd50, '0, '0, '0);
      send_request(MODE_ADVANCE, 31'h7FFFFFFF, '0, '0, '0);
      send_request(MODE_SPARE_LO, 31'h7FFFFFFF, '1, 6'd63, '1);
      send_request(MODE_SPARE_HI, '0, '0, '0, '0);
      send_request(MODE_SCHED, '0, 32'd5, 6'd2, 64'h1);
      send_request(MODE_REMOVE, '0, '0, 6'd2, '0);
      send_request(MODE_SCHED, '0, 32'd500000000, 6'd5, 64'h2);
      send_request(MODE_ADVANCE, '0, '0, '0, '0);
      send_request(MODE_CLEAR, '0, '0, '0, '0);
      for (int k = 0; k < MAX_EVENTS + 2; k++)
         send_request(MODE_SCHED, '0, 32'(k % 3), 6'(k), 64'(k));
      send_request(MODE_ADVANCE, 31'd10, '0, '0, '0);

      // The sender holds off here until every response has come back.
      wait_drained();

      for (int n = 0; n < 375; n++) begin
         if (n == 200) stall_free = 1'b1;
         if (n == 260) stall_free = 1'b0;
         send_random();
      end
      wait_drained();
      if (error_count == 0)
         $display("tb_timed_event_scheduler_core: PASS");
      else
         $display("tb_timed_event_scheduler_core: FAIL");
      $finish;
   end

   initial begin
      #100ms;
      $display("tb_timed_event_scheduler_core: FAIL");
      $finish;
   end
endmodule
